// ===== rtl/core/fjst_pkg.sv =====
// fjst_pkg: shared types and constants for the job scheduler table.
// Used by fjst_slot_ram, fjst_scan and fifo_job_scheduler_table_unit; no dependencies.

package fjst_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int OP_W          = 2;
    localparam int ID_W          = 16;
    localparam int TIME_W        = 32;
    localparam int COUNT_W       = 5;
    localparam int ENTRY_W       = ID_W + TIME_W;

    localparam logic [OP_W-1:0] OP_SET_TIME = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;

    typedef struct packed {
        logic            clear;
        logic            step;
        logic            remove;
        logic [ID_W-1:0] job_id;
    } scan_ctrl_t;

    typedef struct packed {
        logic              match;
        logic              free_found;
        logic              have;
        logic [ID_W-1:0]   best_id;
        logic [TIME_W-1:0] best_arr;
    } scan_res_t;

endpackage

// ===== rtl/core/fifo_job_scheduler_table_unit.sv =====
// fifo_job_scheduler_table_unit: table of waiting jobs served in arrival order.
// Top level: control sequencer, valid bits, current time; uses fjst_pkg, fjst_slot_ram, fjst_scan.
//
// Each item (set time, add job, remove job, or the unused op) takes one pass over
// the slot memory, one slot per cycle through a single read port with registered
// read data, then a final state that commits the add or remove and loads the result
// register, held there while the previous result is not yet taken. The result
// register frees the scan side, but the next item starts only once the result
// register is loaded. An add takes the lowest free slot; a duplicate id is
// ignored; an add to a full table sets full_drop. No clearing pass after reset.

module fifo_job_scheduler_table_unit #(
    parameter int SLOTS = fjst_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // job_id[15:0], time_value[47:16]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // head_id[15:0], added[16], full_drop[17], job_count[22:18]
    output logic [0:0]  m_tuser    // head_valid[0]
);
    import fjst_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [AW:0]       cnt_reg;
    logic [AW-1:0]     p_idx_reg;
    logic              p_vld_reg;
    logic [SLOTS-1:0]  slot_valid_reg;
    logic [TIME_W-1:0] cur_time_reg;
    logic [OP_W-1:0]   op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] tv_reg;

    logic               out_valid_reg;
    logic               head_valid_reg;
    logic [ID_W-1:0]    head_id_reg;
    logic               added_reg;
    logic               drop_reg;
    logic [COUNT_W-1:0] job_count_reg;

    logic               accept;
    logic               out_free;
    logic               commit;
    logic               add_ok;
    logic               add_drop;
    logic               rem_ok;
    logic               cand_wins;
    logic [CW-1:0]      total;
    logic [CW+COUNT_W-1:0] total_ext;

    scan_ctrl_t         ctrl;
    scan_res_t          res;
    logic [AW-1:0]      match_idx;
    logic [AW-1:0]      free_idx;
    logic [CW-1:0]      valid_count;
    logic [ENTRY_W-1:0] rdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign commit   = (state_reg == ST_FINAL) && out_free;

    assign ctrl.clear  = accept;
    assign ctrl.step   = p_vld_reg;
    assign ctrl.remove = (op_reg == OP_REMOVE);
    assign ctrl.job_id = id_reg;

    fjst_slot_ram #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (commit && add_ok),
        .waddr (free_idx),
        .wdata ({id_reg, cur_time_reg}),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rdata)
    );

    fjst_scan #(
        .SLOTS (SLOTS),
        .AW    (AW),
        .CW    (CW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .idx         (p_idx_reg),
        .slot_vld    (slot_valid_reg[p_idx_reg]),
        .rd_id       (rdata[ENTRY_W-1:TIME_W]),
        .rd_arr      (rdata[TIME_W-1:0]),
        .res         (res),
        .match_idx   (match_idx),
        .free_idx    (free_idx),
        .valid_count (valid_count)
    );

    assign add_ok    = (op_reg == OP_ADD) && !res.match && res.free_found;
    assign add_drop  = (op_reg == OP_ADD) && !res.match && !res.free_found;
    assign rem_ok    = (op_reg == OP_REMOVE) && res.match;
    assign cand_wins = !res.have || (cur_time_reg < res.best_arr) ||
                       ((cur_time_reg == res.best_arr) && (id_reg < res.best_id));
    assign total     = valid_count + CW'(add_ok);
    assign total_ext = {{COUNT_W{1'b0}}, total};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == (AW+1)'(SLOTS))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            p_vld_reg      <= 1'b0;
            slot_valid_reg <= '0;
            cur_time_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if ((state_reg == ST_SCAN) && (cnt_reg != (AW+1)'(SLOTS)))
            begin
                cnt_reg <= cnt_reg + (AW+1)'(1);
            end
            p_vld_reg <= (state_reg == ST_SCAN) && (cnt_reg != (AW+1)'(SLOTS));
            if (commit)
            begin
                if (add_ok)
                begin
                    slot_valid_reg[free_idx] <= 1'b1;
                end
                if (rem_ok)
                begin
                    slot_valid_reg[match_idx] <= 1'b0;
                end
                if (op_reg == OP_SET_TIME)
                begin
                    cur_time_reg <= tv_reg;
                end
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= s_tuser;
            id_reg <= s_tdata[15:0];
            tv_reg <= s_tdata[47:16];
        end
        if ((state_reg == ST_SCAN) && (cnt_reg != (AW+1)'(SLOTS)))
        begin
            p_idx_reg <= cnt_reg[AW-1:0];
        end
        if (commit)
        begin
            head_valid_reg <= res.have || add_ok;
            if (add_ok && cand_wins)
            begin
                head_id_reg <= id_reg;
            end
            else if (res.have)
            begin
                head_id_reg <= res.best_id;
            end
            else
            begin
                head_id_reg <= '0;
            end
            added_reg     <= add_ok;
            drop_reg      <= add_drop;
            job_count_reg <= total_ext[COUNT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, job_count_reg, drop_reg, added_reg, head_id_reg};
    assign m_tuser  = head_valid_reg;

    a_add_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && add_ok) |-> !slot_valid_reg[free_idx])
        else $error("add commits over a live slot");

    a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && rem_ok) |=> !slot_valid_reg[$past(match_idx)])
        else $error("remove left slot valid");

    a_head_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (SLOTS < 32)) |-> (head_valid_reg == (job_count_reg != '0)))
        else $error("head_valid disagrees with job_count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (SLOTS < 32)) |-> (32'(job_count_reg) <= 32'(SLOTS)))
        else $error("job_count above table size");

    a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (head_valid_reg || (head_id_reg == '0)))
        else $error("empty table reports nonzero head_id");

endmodule

// ===== rtl/core/fjst_slot_ram.sv =====
// fjst_slot_ram: slot storage, one entry of {id, arrival} per slot.
// Single write port, single read port with registered read data. Uses fjst_pkg.

module fjst_slot_ram #(
    parameter int SLOTS = fjst_pkg::SLOTS_DEFAULT,
    parameter int AW    = $clog2(SLOTS)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [fjst_pkg::ENTRY_W-1:0] wdata,
    input  logic [AW-1:0]                raddr,
    output logic [fjst_pkg::ENTRY_W-1:0] rdata
);
    import fjst_pkg::*;

    logic [ENTRY_W-1:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/fjst_scan.sv =====
// fjst_scan: per-slot accumulator for one table pass: id match, first free slot,
// surviving count and earliest (arrival, id) entry. Uses fjst_pkg.

module fjst_scan #(
    parameter int SLOTS = fjst_pkg::SLOTS_DEFAULT,
    parameter int AW    = $clog2(SLOTS),
    parameter int CW    = $clog2(SLOTS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fjst_pkg::scan_ctrl_t        ctrl,
    input  logic [AW-1:0]               idx,
    input  logic                        slot_vld,
    input  logic [fjst_pkg::ID_W-1:0]   rd_id,
    input  logic [fjst_pkg::TIME_W-1:0] rd_arr,
    output fjst_pkg::scan_res_t         res,
    output logic [AW-1:0]               match_idx,
    output logic [AW-1:0]               free_idx,
    output logic [CW-1:0]               valid_count
);
    import fjst_pkg::*;

    logic              match_reg;
    logic              free_found_reg;
    logic              have_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic [TIME_W-1:0] best_arr_reg;
    logic [AW-1:0]     match_idx_reg;
    logic [AW-1:0]     free_idx_reg;
    logic [CW-1:0]     count_reg;

    logic hit;
    logic keep;
    logic better;

    assign hit    = slot_vld && (rd_id == ctrl.job_id);
    assign keep   = slot_vld && !(ctrl.remove && hit);
    assign better = !have_reg || (rd_arr < best_arr_reg) ||
                    ((rd_arr == best_arr_reg) && (rd_id < best_id_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            have_reg       <= 1'b0;
            count_reg      <= '0;
        end
        else if (ctrl.clear)
        begin
            match_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            have_reg       <= 1'b0;
            count_reg      <= '0;
        end
        else if (ctrl.step)
        begin
            if (hit)
            begin
                match_reg <= 1'b1;
            end
            if (!slot_vld && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (keep)
            begin
                count_reg <= count_reg + CW'(1);
                if (better)
                begin
                    have_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            if (hit)
            begin
                match_idx_reg <= idx;
            end
            if (!slot_vld && !free_found_reg)
            begin
                free_idx_reg <= idx;
            end
            if (keep && better)
            begin
                best_id_reg  <= rd_id;
                best_arr_reg <= rd_arr;
            end
        end
    end

    always_comb
    begin
        res.match      = match_reg;
        res.free_found = free_found_reg;
        res.have       = have_reg;
        res.best_id    = best_id_reg;
        res.best_arr   = best_arr_reg;
    end

    assign match_idx   = match_idx_reg;
    assign free_idx    = free_idx_reg;
    assign valid_count = count_reg;

endmodule

// ===== dv/fifo_job_scheduler_table_checker.sv =====
// Scoreboard for fifo_job_scheduler_table_unit: watches both stream channels, keeps
// its own copy of the job table and checks every result item field by field.
// Depends on fjst_pkg for widths and op codes.

module fifo_job_scheduler_table_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // job_id[15:0], time_value[47:16]
    input  logic [1:0]  s_tuser,   // op[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // head_id[15:0], added[16], full_drop[17], job_count[22:18]
    input  logic [0:0]  m_tuser,   // head_valid[0]
    output int          errors,
    output int          outstanding,
    output int          checked,
    output int          drops
);
    timeunit 1ns;
    timeprecision 1ps;

    import fjst_pkg::*;

    localparam int TABLE_SIZE = SLOTS_DEFAULT;

    typedef struct packed {
        logic               head_valid;
        logic [ID_W-1:0]    head_id;
        logic               added;
        logic               full_drop;
        logic [COUNT_W-1:0] job_count;
    } sched_report_t;

    logic              slot_busy  [TABLE_SIZE];
    logic [ID_W-1:0]   slot_job   [TABLE_SIZE];
    logic [TIME_W-1:0] slot_stamp [TABLE_SIZE];
    logic [TIME_W-1:0] now_time;
    sched_report_t     report_q [$];

    function automatic sched_report_t schedule_step(input logic [OP_W-1:0] op,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [TIME_W-1:0] tv);
        sched_report_t     r;
        int                hit;
        int                free_idx;
        int                n;
        logic              have;
        logic [ID_W-1:0]   best_id;
        logic [TIME_W-1:0] best_stamp;
        r          = '0;
        hit        = -1;
        free_idx   = -1;
        n          = 0;
        have       = 1'b0;
        best_id    = '0;
        best_stamp = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (slot_busy[i] && slot_job[i] == id && hit < 0)
                hit = i;
            if (!slot_busy[i] && free_idx < 0)
                free_idx = i;
        end
        case (op)
            OP_SET_TIME: now_time = tv;
            OP_ADD:
            begin
                if (hit < 0)
                begin
                    if (free_idx < 0)
                        r.full_drop = 1'b1;
                    else
                    begin
                        slot_busy[free_idx]  = 1'b1;
                        slot_job[free_idx]   = id;
                        slot_stamp[free_idx] = now_time;
                        r.added              = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                    slot_busy[hit] = 1'b0;
            end
            default: ;
        endcase
        // earliest arrival wins, smaller id breaks ties
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (slot_busy[i])
            begin
                n++;
                if (!have || slot_stamp[i] < best_stamp ||
                    (slot_stamp[i] == best_stamp && slot_job[i] < best_id))
                begin
                    have       = 1'b1;
                    best_stamp = slot_stamp[i];
                    best_id    = slot_job[i];
                end
            end
        end
        r.head_valid = have;
        r.head_id    = have ? best_id : '0;
        r.job_count  = n[COUNT_W-1:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors = errors + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_report_t got;
        sched_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                slot_busy[i]  = 1'b0;
                slot_job[i]   = '0;
                slot_stamp[i] = '0;
            end
            now_time = '0;
            report_q.delete();
            errors      = 0;
            checked     = 0;
            drops       = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.head_valid = m_tuser[0];
                got.head_id    = m_tdata[15:0];
                got.added      = m_tdata[16];
                got.full_drop  = m_tdata[17];
                got.job_count  = m_tdata[22:18];
                if (report_q.size() == 0)
                begin
                    $display("%0t: result item with nothing expected: expected none, actual %p",
                             $time, got);
                    errors = errors + 1;
                end
                else
                begin
                    want = report_q.pop_front();
                    compare_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
                    compare_field("head_id", 32'(want.head_id), 32'(got.head_id));
                    compare_field("added", 32'(want.added), 32'(got.added));
                    compare_field("full_drop", 32'(want.full_drop), 32'(got.full_drop));
                    compare_field("job_count", 32'(want.job_count), 32'(got.job_count));
                    checked = checked + 1;
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = schedule_step(s_tuser, s_tdata[15:0], s_tdata[47:16]);
                if (want.full_drop)
                    drops = drops + 1;
                report_q.push_back(want);
            end
            outstanding <= report_q.size();
        end
    end

endmodule

// ===== dv/fifo_job_scheduler_table_unit_test.sv =====
// Top of the job scheduler table testbench: clock, reset, directed and random
// stimulus with source gaps and sink stalls, watchdog and verdict.
// Depends on fjst_pkg, fifo_job_scheduler_table_unit and fifo_job_scheduler_table_checker.

module fifo_job_scheduler_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fjst_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 300;
    localparam int PHASE_FILL    = 0;
    localparam int PHASE_DRAIN   = 1;
    localparam int PHASE_MIX     = 2;
    localparam int POOL_SIZE     = 24;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // job_id[15:0], time_value[47:16]
    logic [1:0]  s_tuser;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // head_id[15:0], added[16], full_drop[17], job_count[22:18]
    logic [0:0]  m_tuser;   // head_valid[0]

    int errors;
    int outstanding;
    int checked;
    int drops;
    int n_sent;
    int burst_left;
    int idle_cycles;
    bit hold_done;

    fifo_job_scheduler_table_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fifo_job_scheduler_table_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked),
        .drops       (drops)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] tv);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tv, id};
        do
            @(posedge clk);
        while (!s_tready);
        n_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 4);
        end
    endtask

    // source side: reset, directed items, random phases, drain and verdict
    initial
    begin
        logic [ID_W-1:0]   id_pool [POOL_SIZE];
        logic [TIME_W-1:0] clock_now;
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] tv;
        int                n_random;
        int                phase;
        int                phase_left;
        int                add_pct;
        int                rem_pct;
        int                roll;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        n_sent     = 0;
        burst_left = 0;
        n_random   = 0;
        phase      = PHASE_MIX;
        phase_left = 0;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = ID_W'($urandom);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, unsigned time order, ties, duplicates, full table
        send_item(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_REMOVE, 16'h1234, $urandom);
        send_item(OP_SET_TIME, ID_W'($urandom), 32'hFFFF_FFFF);
        send_item(OP_ADD, 16'hFFFF, $urandom);
        send_item(OP_ADD, 16'h0000, $urandom);
        send_item(OP_ADD, 16'hFFFF, $urandom);
        send_item(OP_SET_TIME, ID_W'($urandom), 32'h0000_0000);
        send_item(OP_ADD, 16'h8000, $urandom);
        send_item(OP_SET_TIME, ID_W'($urandom), 32'h8000_0000);
        for (int i = 1; i <= 13; i++)
            send_item(OP_ADD, i[ID_W-1:0], $urandom);
        send_item(OP_ADD, 16'h5555, $urandom);
        send_item(OP_ADD, 16'h0001, $urandom);
        send_item(OP_REMOVE, 16'h8000, $urandom);
        clock_now = 32'h8000_0000;

        while (n_random < RANDOM_ITEMS)
        begin
            if (phase_left == 0)
            begin
                phase      = $urandom_range(PHASE_FILL, PHASE_MIX);
                phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            case (phase)
                PHASE_FILL:
                begin
                    add_pct = 55;
                    rem_pct = 15;
                end
                PHASE_DRAIN:
                begin
                    add_pct = 20;
                    rem_pct = 50;
                end
                default:
                begin
                    add_pct = 35;
                    rem_pct = 35;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                op = OP_ADD;
            else if (roll < add_pct + rem_pct)
                op = OP_REMOVE;
            else if (roll < 95)
                op = OP_SET_TIME;
            else
                op = OP_UNUSED;
            id = ($urandom_range(0, 7) == 0) ? ID_W'($urandom)
                                             : id_pool[$urandom_range(0, POOL_SIZE - 1)];
            tv = $urandom;
            if (op == OP_SET_TIME)
            begin
                roll = $urandom_range(0, 9);
                if (roll <= 5)
                    tv = clock_now + $urandom_range(0, 3);
                else if (roll <= 7)
                    tv = clock_now + $urandom_range(0, 5000);
                else if (roll == 9)
                    tv = 32'hFFFF_FFFF - $urandom_range(0, 3);
                clock_now = tv;
            end
            send_item(op, id, tv);
            n_random++;
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d items: all four op codes, id and time extremes, ties, duplicates,",
                 n_sent);
        $display("%0d full-table drops; %0d results checked under source gaps and sink stalls.",
                 drops, checked);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // sink side: stall patterns that change now and then, one long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int cyc;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        mode      = 0;
        mode_left = 0;
        cyc       = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (rst_n && !hold_done && n_sent >= HOLD_AFTER)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (cyc % 4 == 0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, outstanding);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
rtl/core/fjst_pkg.sv
rtl/core/fjst_slot_ram.sv
rtl/core/fjst_scan.sv
rtl/core/fifo_job_scheduler_table_unit.sv
dv/fifo_job_scheduler_table_checker.sv
dv/fifo_job_scheduler_table_unit_test.sv
